// File: rtl/qsra_pkg.sv
// Shared constants and arithmetic helpers for the quaternion slerp running average.
// No dependencies; the top module and the testbench import this package.
package qsra_pkg;

    localparam int FRAC_BITS    = 14;
    localparam int WB           = 30;
    localparam int CORDIC_ITERS = 16;
    localparam int CI_W         = $clog2(CORDIC_ITERS);
    localparam int ONE          = 1 << FRAC_BITS;

    localparam logic [14:0] THR_RESET    = 15'd16376;
    localparam logic        REG_NEAR_THR = 1'b0;

    // CORDIC arctangent table, radians in Q30.
    function automatic logic signed [35:0] atan_q30(input logic [CI_W-1:0] i);
        logic signed [35:0] v;
        case (i)
            0:       v = 36'sd843314857;
            1:       v = 36'sd497837829;
            2:       v = 36'sd263043837;
            3:       v = 36'sd133525159;
            4:       v = 36'sd67021687;
            5:       v = 36'sd33543516;
            6:       v = 36'sd16775851;
            7:       v = 36'sd8388437;
            8:       v = 36'sd4194283;
            9:       v = 36'sd2097149;
            default: v = 36'sd1 <<< (WB - int'(i));
        endcase
        return v;
    endfunction

    // Shift right by WB with rounding half away from zero.
    function automatic logic signed [71:0] rshr30(input logic signed [71:0] v);
        logic signed [71:0] half;
        half = 72'sd1 <<< (WB - 1);
        if (v >= 0) begin
            return (v + half) >>> WB;
        end
        return -((-v + half) >>> WB);
    endfunction

    // Clamp a result component to [-ONE, ONE].
    function automatic logic signed [15:0] sat_out(input logic signed [19:0] v);
        if (v > 20'(ONE)) begin
            return 16'(ONE);
        end
        if (v < -20'(ONE)) begin
            return -16'(ONE);
        end
        return v[15:0];
    endfunction

endpackage

// File: rtl/qsra_if.sv
// Valid/ready channel interfaces for the quaternion slerp running average.
// No dependencies.
interface qsra_in_if;
    logic               valid;
    logic               ready;
    logic               start_req;
    logic signed [15:0] in_w;
    logic signed [15:0] in_x;
    logic signed [15:0] in_y;
    logic signed [15:0] in_z;
    logic        [15:0] weight;

    modport source (output valid, start_req, in_w, in_x, in_y, in_z, weight, input ready);
    modport sink   (input valid, start_req, in_w, in_x, in_y, in_z, weight, output ready);
endinterface

interface qsra_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] avg_w;
    logic signed [15:0] avg_x;
    logic signed [15:0] avg_y;
    logic signed [15:0] avg_z;
    logic               weight_fault;

    modport source (output valid, avg_w, avg_x, avg_y, avg_z, weight_fault, input ready);
    modport sink   (input valid, avg_w, avg_x, avg_y, avg_z, weight_fault, output ready);
endinterface

// File: rtl/quaternion_slerp_running_average_top.sv
// Start items: the average is loaded on acceptance and the result is registered from S_DONE.
// Linear and slerp items use the serial divider
// (one quotient bit per cycle, up to 64 bits), the bit-serial square root (31 steps) and,
// for slerp items, the 16-step CORDIC unit, all run one after another.
// One transaction is in flight at a time; input ready is high only while idle.
// Synchronous active-low reset: average = identity, total = 0, threshold = 16376.
module quaternion_slerp_running_average_top
    import qsra_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    qsra_in_if.sink     i_in,
    qsra_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [4:0] {
        S_IDLE, S_TDIV, S_DOT_M, S_DOT_A, S_SIGN, S_LIN_M, S_LIN_A, S_N2_M, S_N2_A,
        S_NQ, S_NDIV, S_NDIV_W, S_CC_M, S_SQ_ST, S_SQ_W, S_VEC_W, S_TH_M, S_TH,
        S_GAIN_W, S_ROT1_W, S_ROT2_W, S_CS_W, S_S1_W, S_CS1_M, S_S0, S_BL_M1,
        S_BL_M2, S_BL_A, S_WRITE, S_DONE
    } t_state;

    t_state r_state;

    logic        [14:0] r_thr;
    logic signed [15:0] r_avg [4];
    logic        [31:0] r_total;
    logic               r_have;
    logic signed [16:0] r_b [4];
    logic        [32:0] r_sum;
    logic        [30:0] r_t;
    logic               r_fault;
    logic        [1:0]  r_k;
    logic signed [69:0] r_p;
    logic signed [71:0] r_acc;
    logic signed [19:0] r_r [4];
    logic        [30:0] r_root;
    logic        [30:0] r_c;
    logic        [31:0] r_th0;
    logic        [31:0] r_th;
    logic signed [35:0] r_gain;
    logic signed [35:0] r_ct;
    logic signed [35:0] r_st;
    logic signed [35:0] r_st0;
    logic signed [35:0] r_cs;
    logic signed [35:0] r_s0;
    logic        [31:0] r_s1;

    logic               r_ovalid;
    logic signed [15:0] r_oq [4];
    logic               r_ofault;

    // Serial restoring divider.
    logic        [63:0] r_dv_num;
    logic        [35:0] r_dv_den;
    logic        [35:0] r_dv_rem;
    logic        [63:0] r_dv_q;
    logic        [6:0]  r_dv_cnt;
    logic               r_dv_busy;
    logic               r_dv_neg;

    // Bit-serial integer square root.
    logic        [60:0] r_sq_n;
    logic        [60:0] r_sq_r;
    logic        [60:0] r_sq_bit;
    logic               r_sq_busy;

    // CORDIC unit, vectoring or rotation.
    logic signed [35:0] r_cx;
    logic signed [35:0] r_cy;
    logic signed [35:0] r_cz;
    logic [CI_W-1:0]    r_ci;
    logic               r_cr_busy;
    logic               r_cr_rot;

    logic signed [36:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [69:0] mul_p;

    logic        [36:0] dv_sh;
    logic               dv_ge;
    logic        [35:0] dv_rem_n;
    logic        [60:0] sq_sum;
    logic               sq_ge;
    logic signed [35:0] cr_dx;
    logic signed [35:0] cr_dy;
    logic signed [35:0] cr_at;
    logic               cr_sub;

    logic        [32:0] n_sum;
    logic signed [71:0] d_abs;
    logic        [71:0] thr_q;
    logic        [71:0] c_full;
    logic        [30:0] c_val;
    logic signed [71:0] acc_sum;
    logic        [19:0] rk_mag;
    logic        [35:0] ct_mag;
    logic        [35:0] st_mag;

    assign n_sum   = {1'b0, r_total} + 33'(i_in.weight);
    assign d_abs   = r_acc[71] ? -r_acc : r_acc;
    assign thr_q   = 72'(r_thr) << FRAC_BITS;
    assign c_full  = 72'(d_abs) << (WB - 2 * FRAC_BITS);
    assign c_val   = (c_full > (72'd1 << WB)) ? 31'(72'd1 << WB) : c_full[30:0];
    assign acc_sum = r_acc + 72'(r_p);
    assign rk_mag  = r_r[r_k][19] ? 20'(-r_r[r_k]) : 20'(r_r[r_k]);
    assign ct_mag  = r_ct[35] ? 36'(-r_ct) : 36'(r_ct);
    assign st_mag  = r_st[35] ? 36'(-r_st) : 36'(r_st);

    // Shared multiplier; the product is always registered into r_p.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_DOT_M: begin
                mul_a = 37'(r_b[r_k]);
                mul_b = 33'(r_avg[r_k]);
            end
            S_LIN_M: begin
                mul_a = 37'(r_b[r_k]) - 37'(r_avg[r_k]);
                mul_b = 33'(r_t);
            end
            S_N2_M: begin
                mul_a = 37'(r_r[r_k]);
                mul_b = 33'(r_r[r_k]);
            end
            S_CC_M: begin
                mul_a = 37'(r_c);
                mul_b = 33'(r_c);
            end
            S_TH_M: begin
                mul_a = 37'(r_th0);
                mul_b = 33'(r_t);
            end
            S_CS1_M: begin
                mul_a = 37'(r_s1);
                mul_b = 33'(r_c);
            end
            S_BL_M1: begin
                mul_a = 37'(r_s0);
                mul_b = 33'(r_avg[r_k]);
            end
            S_BL_M2: begin
                mul_a = 37'(r_s1);
                mul_b = 33'(r_b[r_k]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign dv_sh    = {r_dv_rem, r_dv_num[63]};
    assign dv_ge    = dv_sh >= {1'b0, r_dv_den};
    assign dv_rem_n = dv_ge ? 36'(dv_sh - {1'b0, r_dv_den}) : dv_sh[35:0];

    assign sq_sum = r_sq_r + r_sq_bit;
    assign sq_ge  = r_sq_n >= sq_sum;

    assign cr_dx  = r_cy >>> r_ci;
    assign cr_dy  = r_cx >>> r_ci;
    assign cr_at  = atan_q30(r_ci);
    assign cr_sub = r_cr_rot ? (r_cz >= 0) : (r_cy <= 0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_thr     <= THR_RESET;
            r_avg[0]  <= 16'(ONE);
            r_avg[1]  <= '0;
            r_avg[2]  <= '0;
            r_avg[3]  <= '0;
            r_total   <= '0;
            r_have    <= 1'b0;
            r_ovalid  <= 1'b0;
            r_dv_busy <= 1'b0;
            r_sq_busy <= 1'b0;
            r_cr_busy <= 1'b0;
        end else begin
            r_p <= mul_p;

            if (psel && penable && pwrite && paddr[2] == REG_NEAR_THR) begin
                r_thr <= pwdata[14:0];
            end

            if (r_ovalid && o_out.ready) begin
                r_ovalid <= 1'b0;
            end

            if (r_dv_busy) begin
                r_dv_num <= r_dv_num << 1;
                r_dv_rem <= dv_rem_n;
                r_dv_q   <= {r_dv_q[62:0], dv_ge};
                r_dv_cnt <= r_dv_cnt - 7'd1;
                if (r_dv_cnt == 7'd1) begin
                    r_dv_busy <= 1'b0;
                end
            end

            if (r_sq_busy) begin
                if (sq_ge) begin
                    r_sq_n <= r_sq_n - sq_sum;
                    r_sq_r <= (r_sq_r >> 1) + r_sq_bit;
                end else begin
                    r_sq_r <= r_sq_r >> 1;
                end
                r_sq_bit <= r_sq_bit >> 2;
                if (r_sq_bit == 61'd1) begin
                    r_sq_busy <= 1'b0;
                end
            end

            if (r_cr_busy) begin
                if (cr_sub) begin
                    r_cx <= r_cx - cr_dx;
                    r_cy <= r_cy + cr_dy;
                    r_cz <= r_cz - cr_at;
                end else begin
                    r_cx <= r_cx + cr_dx;
                    r_cy <= r_cy - cr_dy;
                    r_cz <= r_cz + cr_at;
                end
                r_ci <= r_ci + 1'b1;
                if (r_ci == CI_W'(CORDIC_ITERS - 1)) begin
                    r_cr_busy <= 1'b0;
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_b[0] <= 17'(i_in.in_w);
                        r_b[1] <= 17'(i_in.in_x);
                        r_b[2] <= 17'(i_in.in_y);
                        r_b[3] <= 17'(i_in.in_z);
                        if (i_in.start_req || !r_have) begin
                            r_avg[0] <= i_in.in_w;
                            r_avg[1] <= i_in.in_x;
                            r_avg[2] <= i_in.in_y;
                            r_avg[3] <= i_in.in_z;
                            r_total  <= 32'(i_in.weight);
                            r_have   <= 1'b1;
                            r_fault  <= 1'b0;
                            r_state  <= S_DONE;
                        end else begin
                            r_sum   <= n_sum;
                            r_fault <= (n_sum == '0);
                            r_k     <= '0;
                            r_acc   <= '0;
                            if (n_sum == '0) begin
                                r_t     <= '0;
                                r_state <= S_DOT_M;
                            end else begin
                                // Blend factor: (weight << 30) / sum, 46 dividend bits.
                                r_dv_num  <= {i_in.weight, 48'd0};
                                r_dv_den  <= 36'(n_sum);
                                r_dv_rem  <= '0;
                                r_dv_q    <= '0;
                                r_dv_cnt  <= 7'd46;
                                r_dv_neg  <= 1'b0;
                                r_dv_busy <= 1'b1;
                                r_state   <= S_TDIV;
                            end
                        end
                    end
                end
                S_TDIV: begin
                    if (!r_dv_busy) begin
                        r_t     <= r_dv_q[30:0];
                        r_state <= S_DOT_M;
                    end
                end
                S_DOT_M: begin
                    r_state <= S_DOT_A;
                end
                S_DOT_A: begin
                    r_acc <= acc_sum;
                    if (r_k == 2'd3) begin
                        r_k     <= '0;
                        r_state <= S_SIGN;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= S_DOT_M;
                    end
                end
                S_SIGN: begin
                    // Take the shorter arc: flip the item when the dot product is negative.
                    if (r_acc[71]) begin
                        for (int i = 0; i < 4; i++) begin
                            r_b[i] <= -r_b[i];
                        end
                    end
                    r_acc <= d_abs;
                    if (d_abs > thr_q) begin
                        r_state <= S_LIN_M;
                    end else begin
                        r_c     <= c_val;
                        r_state <= S_CC_M;
                    end
                end
                S_LIN_M: begin
                    r_state <= S_LIN_A;
                end
                S_LIN_A: begin
                    r_r[r_k] <= 20'(72'(r_avg[r_k]) + rshr30(72'(r_p)));
                    if (r_k == 2'd3) begin
                        r_k     <= '0;
                        r_acc   <= '0;
                        r_state <= S_N2_M;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= S_LIN_M;
                    end
                end
                S_N2_M: begin
                    r_state <= S_N2_A;
                end
                S_N2_A: begin
                    r_acc <= acc_sum;
                    if (r_k == 2'd3) begin
                        r_k <= '0;
                        if (acc_sum == '0) begin
                            r_state <= S_WRITE;
                        end else begin
                            r_sq_n    <= 61'(acc_sum) << 16;
                            r_sq_r    <= '0;
                            r_sq_bit  <= 61'd1 << 60;
                            r_sq_busy <= 1'b1;
                            r_state   <= S_NQ;
                        end
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= S_N2_M;
                    end
                end
                S_NQ: begin
                    if (!r_sq_busy) begin
                        r_root  <= r_sq_r[30:0];
                        r_state <= S_NDIV;
                    end
                end
                S_NDIV: begin
                    // Rounded |r| * 2^22 / norm, 42 dividend bits.
                    r_dv_num  <= ((64'(rk_mag) << 22) + 64'(r_root[30:1])) << 22;
                    r_dv_den  <= 36'(r_root);
                    r_dv_rem  <= '0;
                    r_dv_q    <= '0;
                    r_dv_cnt  <= 7'd42;
                    r_dv_neg  <= r_r[r_k][19];
                    r_dv_busy <= 1'b1;
                    r_state   <= S_NDIV_W;
                end
                S_NDIV_W: begin
                    if (!r_dv_busy) begin
                        r_r[r_k] <= r_dv_neg ? -(20'(r_dv_q)) : 20'(r_dv_q);
                        if (r_k == 2'd3) begin
                            r_k     <= '0;
                            r_state <= S_WRITE;
                        end else begin
                            r_k     <= r_k + 2'd1;
                            r_state <= S_NDIV;
                        end
                    end
                end
                S_CC_M: begin
                    r_state <= S_SQ_ST;
                end
                S_SQ_ST: begin
                    r_sq_n    <= (61'd1 << 60) - 61'(r_p);
                    r_sq_r    <= '0;
                    r_sq_bit  <= 61'd1 << 60;
                    r_sq_busy <= 1'b1;
                    r_state   <= S_SQ_W;
                end
                S_SQ_W: begin
                    if (!r_sq_busy) begin
                        r_cx      <= 36'(r_c);
                        r_cy      <= 36'(r_sq_r[30:0]);
                        r_cz      <= '0;
                        r_ci      <= '0;
                        r_cr_rot  <= 1'b0;
                        r_cr_busy <= 1'b1;
                        r_state   <= S_VEC_W;
                    end
                end
                S_VEC_W: begin
                    if (!r_cr_busy) begin
                        r_th0   <= r_cz[35] ? 32'd0 : 32'(r_cz);
                        r_state <= S_TH_M;
                    end
                end
                S_TH_M: begin
                    r_state <= S_TH;
                end
                S_TH: begin
                    r_th      <= 32'(r_p >>> WB);
                    // Vectoring the unit vector gives the CORDIC gain.
                    r_cx      <= 36'sd1 <<< WB;
                    r_cy      <= '0;
                    r_cz      <= '0;
                    r_ci      <= '0;
                    r_cr_rot  <= 1'b0;
                    r_cr_busy <= 1'b1;
                    r_state   <= S_GAIN_W;
                end
                S_GAIN_W: begin
                    if (!r_cr_busy) begin
                        r_gain    <= r_cx;
                        r_cx      <= 36'sd1 <<< WB;
                        r_cy      <= '0;
                        r_cz      <= 36'(r_th);
                        r_ci      <= '0;
                        r_cr_rot  <= 1'b1;
                        r_cr_busy <= 1'b1;
                        r_state   <= S_ROT1_W;
                    end
                end
                S_ROT1_W: begin
                    if (!r_cr_busy) begin
                        r_ct      <= r_cx;
                        r_st      <= r_cy;
                        r_cx      <= 36'sd1 <<< WB;
                        r_cy      <= '0;
                        r_cz      <= 36'(r_th0);
                        r_ci      <= '0;
                        r_cr_rot  <= 1'b1;
                        r_cr_busy <= 1'b1;
                        r_state   <= S_ROT2_W;
                    end
                end
                S_ROT2_W: begin
                    if (!r_cr_busy) begin
                        r_st0 <= r_cy;
                        r_k   <= '0;
                        if (r_cy > 0 && r_gain > 0) begin
                            r_dv_num  <= (64'(ct_mag) << WB) + 64'(r_gain >>> 1);
                            r_dv_den  <= r_gain;
                            r_dv_rem  <= '0;
                            r_dv_q    <= '0;
                            r_dv_cnt  <= 7'd64;
                            r_dv_neg  <= r_ct[35];
                            r_dv_busy <= 1'b1;
                            r_state   <= S_CS_W;
                        end else begin
                            // Degenerate sine: plain weighted blend.
                            r_s1    <= 32'(r_t);
                            r_s0    <= (36'sd1 <<< WB) - 36'(r_t);
                            r_state <= S_BL_M1;
                        end
                    end
                end
                S_CS_W: begin
                    if (!r_dv_busy) begin
                        r_cs      <= r_dv_neg ? -(36'(r_dv_q)) : 36'(r_dv_q);
                        r_dv_num  <= (64'(st_mag) << WB) + 64'(r_st0 >>> 1);
                        r_dv_den  <= r_st0;
                        r_dv_rem  <= '0;
                        r_dv_q    <= '0;
                        r_dv_cnt  <= 7'd64;
                        r_dv_neg  <= r_st[35];
                        r_dv_busy <= 1'b1;
                        r_state   <= S_S1_W;
                    end
                end
                S_S1_W: begin
                    if (!r_dv_busy) begin
                        if (r_dv_neg) begin
                            r_s1 <= '0;
                        end else if (r_dv_q > (64'd1 << 31)) begin
                            r_s1 <= 32'h8000_0000;
                        end else begin
                            r_s1 <= r_dv_q[31:0];
                        end
                        r_state <= S_CS1_M;
                    end
                end
                S_CS1_M: begin
                    r_state <= S_S0;
                end
                S_S0: begin
                    r_s0    <= 36'(72'(r_cs) - rshr30(72'(r_p)));
                    r_k     <= '0;
                    r_state <= S_BL_M1;
                end
                S_BL_M1: begin
                    r_state <= S_BL_M2;
                end
                S_BL_M2: begin
                    r_acc   <= 72'(r_p);
                    r_state <= S_BL_A;
                end
                S_BL_A: begin
                    r_r[r_k] <= 20'(rshr30(acc_sum));
                    if (r_k == 2'd3) begin
                        r_k     <= '0;
                        r_state <= S_WRITE;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= S_BL_M1;
                    end
                end
                S_WRITE: begin
                    for (int i = 0; i < 4; i++) begin
                        r_avg[i] <= sat_out(r_r[i]);
                    end
                    r_total <= r_sum[32] ? 32'hFFFF_FFFF : r_sum[31:0];
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ovalid || o_out.ready) begin
                        r_oq[0]  <= r_avg[0];
                        r_oq[1]  <= r_avg[1];
                        r_oq[2]  <= r_avg[2];
                        r_oq[3]  <= r_avg[3];
                        r_ofault <= r_fault;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_ovalid;
    assign o_out.avg_w        = r_oq[0];
    assign o_out.avg_x        = r_oq[1];
    assign o_out.avg_y        = r_oq[2];
    assign o_out.avg_z        = r_oq[3];
    assign o_out.weight_fault = r_ofault;

    assign prdata = (paddr[2] == REG_NEAR_THR) ? 32'(r_thr) : 32'd0;
    assign pready = 1'b1;

endmodule

// File: tb/sv/quaternion_slerp_running_average_top_test.sv
// Self-checking testbench for quaternion_slerp_running_average_top: a directed table, then
// random weighted quaternion streams under several near-threshold settings.
// Depends on qsra_pkg and the qsra_in_if / qsra_out_if channel interfaces.
module quaternion_slerp_running_average_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import qsra_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int RANDOM_PER_PHASE = 230;

    typedef struct {
        logic signed [15:0] w, x, y, z;
        logic               fault;
    } avg_result_t;

    typedef struct {
        int  thr;       // -1 keeps the current threshold
        bit  start;
        int  w, x, y, z, wt;
        bit  typed;
        int  ew, ex, ey, ez;
        bit  ef;
    } stim_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    qsra_in_if  in_ch();
    qsra_out_if out_ch();

    quaternion_slerp_running_average_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .o_out(out_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predictor state.
    longint          avg_q[4];
    longint unsigned total_wt;
    bit              have_set;
    longint          thr_model;

    avg_result_t pending_avgs[$];
    int  errors = 0;
    int  rx_stall_pct = 20;
    int  hold_cycles = 0;
    longint cycles = 0;

    const longint ATAN_TBL[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                                   33543516, 16775851, 8388437, 4194283, 2097149};

    function automatic longint atan_at(int i);
        if (i < 10) return ATAN_TBL[i];
        if (i <= 30) return longint'(1) << (30 - i);
        return 0;
    endfunction

    function automatic longint round30(longint v);
        longint h;
        h = longint'(1) << 29;
        return v >= 0 ? (v + h) >>> 30 : -(((-v) + h) >>> 30);
    endfunction

    function automatic longint div_near(longint n, longint d);
        return n >= 0 ? (n + d / 2) / d : -(((-n) + d / 2) / d);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint cordic_angle(longint x, longint y, output longint x_out);
        longint z, dx, dy;
        z = 0;
        for (int i = 0; i < CORDIC_ITERS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; z += atan_at(i);
            end else begin
                x -= dx; y += dy; z -= atan_at(i);
            end
        end
        x_out = x;
        return z;
    endfunction

    function automatic void cordic_sincos(longint z, output longint c, output longint s);
        longint x, y, dx, dy;
        x = longint'(1) << 30;
        y = 0;
        for (int i = 0; i < CORDIC_ITERS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_at(i);
            end else begin
                x += dx; y -= dy; z += atan_at(i);
            end
        end
        c = x;
        s = y;
    endfunction

    function automatic longint clamp_one(longint v);
        if (v > ONE) return ONE;
        if (v < -ONE) return -ONE;
        return v;
    endfunction

    function automatic void slerp_toward(longint b_in[4], longint t);
        longint b[4], r[4], d;
        longint unsigned n2;
        longint c, s, th0, th, gain, ct, st, c0, st0, cs, s0, s1, nq;
        d = 0;
        for (int i = 0; i < 4; i++) begin
            b[i] = b_in[i];
            d += avg_q[i] * b[i];
        end
        if (d < 0) begin
            d = -d;
            for (int i = 0; i < 4; i++) b[i] = -b[i];
        end
        if (d > (thr_model << FRAC_BITS)) begin
            n2 = 0;
            for (int i = 0; i < 4; i++) begin
                r[i] = avg_q[i] + round30(t * (b[i] - avg_q[i]));
                n2 += longint'(r[i] * r[i]);
            end
            if (n2 != 0) begin
                nq = longint'(int_sqrt(n2 << 16));
                for (int i = 0; i < 4; i++) r[i] = div_near(r[i] * (longint'(1) << 22), nq);
            end
        end else begin
            c = d << (30 - 2 * FRAC_BITS);
            if (c > (longint'(1) << 30)) c = longint'(1) << 30;
            s = longint'(int_sqrt((64'd1 << 60) - longint'(c) * longint'(c)));
            th0 = cordic_angle(c, s, gain);
            if (th0 < 0) th0 = 0;
            th = (th0 * t) >>> 30;
            void'(cordic_angle(longint'(1) << 30, 0, gain));
            cordic_sincos(th, ct, st);
            cordic_sincos(th0, c0, st0);
            if (st0 > 0 && gain > 0) begin
                cs = div_near(ct * (longint'(1) << 30), gain);
                s1 = div_near(st * (longint'(1) << 30), st0);
                if (s1 < 0) s1 = 0;
                if (s1 > (longint'(1) << 31)) s1 = longint'(1) << 31;
                s0 = cs - round30(c * s1);
            end else begin
                s1 = t;
                s0 = (longint'(1) << 30) - t;
            end
            for (int i = 0; i < 4; i++) r[i] = round30(s0 * avg_q[i] + s1 * b[i]);
        end
        for (int i = 0; i < 4; i++) avg_q[i] = clamp_one(r[i]);
    endfunction

    function automatic avg_result_t predict_average(bit start, logic signed [15:0] q[4],
                                                    logic [15:0] wt);
        avg_result_t res;
        longint b[4];
        longint unsigned sum;
        longint t;
        res.fault = 1'b0;
        for (int i = 0; i < 4; i++) b[i] = q[i];
        if (start || !have_set) begin
            for (int i = 0; i < 4; i++) avg_q[i] = b[i];
            total_wt = wt;
            have_set = 1'b1;
        end else begin
            sum = total_wt + wt;
            t = 0;
            if (sum == 0) res.fault = 1'b1;
            else t = longint'((longint'(wt) << 30) / sum);
            total_wt = sum > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : sum;
            slerp_toward(b, t);
        end
        res.w = avg_q[0][15:0];
        res.x = avg_q[1][15:0];
        res.y = avg_q[2][15:0];
        res.z = avg_q[3][15:0];
        return res;
    endfunction

    // Offer one transaction and hold it until the block accepts it.
    task automatic send_item(bit start, int w, int x, int y, int z, int wt,
                             output avg_result_t res);
        logic signed [15:0] q[4];
        q = '{16'(w), 16'(x), 16'(y), 16'(z)};
        in_ch.valid     <= 1'b1;
        in_ch.start_req <= start;
        in_ch.in_w      <= q[0];
        in_ch.in_x      <= q[1];
        in_ch.in_y      <= q[2];
        in_ch.in_z      <= q[3];
        in_ch.weight    <= 16'(wt);
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        res = predict_average(start, q, 16'(wt));
        pending_avgs.push_back(res);
    endtask

    task automatic sender_gap();
        int r, n;
        r = $urandom_range(0, 99);
        n = r < 70 ? 0 : (r < 95 ? $urandom_range(1, 3) : $urandom_range(10, 60));
        if (n > 0) begin
            in_ch.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain_and_idle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_avgs.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_threshold(int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * REG_NEAR_THR);
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        thr_model = value & 16'h7FFF;
        @(posedge i_clk);
    endtask

    function automatic int rand_comp();
        return $urandom_range(0, 32768) - 16384;
    endfunction

    function automatic int near_comp(longint base);
        return int'(clamp_one(base + $urandom_range(0, 16) - 8));
    endfunction

    function automatic int rand_weight();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return 0;
        if (r < 14) return 16'hFFFF;
        if (r < 50) return $urandom_range(1, 1023);
        return $urandom_range(0, 16'hFFFF);
    endfunction

    // Receiver: checks each transaction and idles the ready at random.
    initial begin
        avg_result_t exp_avg;
        out_ch.ready = 1'b1;
        forever begin
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready) begin
                if (pending_avgs.size() == 0) begin
                    $display("%0t: result with nothing expected: %0d %0d %0d %0d f=%0b",
                             $realtime, out_ch.avg_w, out_ch.avg_x, out_ch.avg_y,
                             out_ch.avg_z, out_ch.weight_fault);
                    errors++;
                end else begin
                    exp_avg = pending_avgs.pop_front();
                    if (out_ch.avg_w !== exp_avg.w || out_ch.avg_x !== exp_avg.x ||
                        out_ch.avg_y !== exp_avg.y || out_ch.avg_z !== exp_avg.z ||
                        out_ch.weight_fault !== exp_avg.fault) begin
                        $display("%0t: mismatch expected %0d %0d %0d %0d f=%0b actual %0d %0d %0d %0d f=%0b",
                                 $realtime, exp_avg.w, exp_avg.x, exp_avg.y, exp_avg.z,
                                 exp_avg.fault, out_ch.avg_w, out_ch.avg_x, out_ch.avg_y,
                                 out_ch.avg_z, out_ch.weight_fault);
                        errors++;
                    end
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                out_ch.ready <= 1'b0;
            end else if ($urandom_range(0, 199) == 0 && rx_stall_pct > 0) begin
                hold_cycles = $urandom_range(20, 150);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("quaternion_slerp_running_average_top_test: FAIL");
            $finish;
        end
    end

    initial begin
        stim_row_t   rows[$];
        avg_result_t res;
        int          thr_list[5];
        bit          start;
        int          w, x, y, z, kind;

        // Items before any start act as a start; the zero weight sum forces the fault.
        rows = '{
            '{-1, 0, 16384, 0, 0, 0, 256, 1, 16384, 0, 0, 0, 0},
            '{-1, 0, 0, 16384, 0, 0, 256, 0, 0, 0, 0, 0, 0},
            '{-1, 1, -16384, -16384, -16384, -16384, 65535, 1, -16384, -16384, -16384, -16384, 0},
            '{-1, 0, 16384, 16384, 16384, 16384, 65535, 0, 0, 0, 0, 0, 0},
            '{-1, 1, 16384, 0, 0, 0, 0, 1, 16384, 0, 0, 0, 0},
            '{-1, 0, 0, 0, 16384, 0, 0, 0, 0, 0, 0, 0, 0},
            '{-1, 0, 16384, 0, 0, 0, 100, 0, 0, 0, 0, 0, 0},
            '{-1, 1, 0, 0, 0, 0, 5, 1, 0, 0, 0, 0, 0},
            '{-1, 0, 0, 0, 0, -16384, 5, 0, 0, 0, 0, 0, 0},
            '{-1, 1, 12345, -3, 7, -16384, 1, 1, 12345, -3, 7, -16384, 0},
            '{-1, 0, 12340, 0, 5, -16380, 65535, 0, 0, 0, 0, 0, 0},
            '{-1, 1, 8192, 8192, 8192, 8192, 128, 1, 8192, 8192, 8192, 8192, 0},
            '{-1, 0, 8193, 8191, 8192, 8192, 128, 0, 0, 0, 0, 0, 0},
            '{16384, 1, 16384, 0, 0, 0, 10, 1, 16384, 0, 0, 0, 0},
            '{-1, 0, 16384, 0, 0, 0, 30, 0, 0, 0, 0, 0, 0},
            '{-1, 0, 0, 16384, 0, 0, 40, 0, 0, 0, 0, 0, 0},
            '{0, 1, 16384, 0, 0, 0, 300, 1, 16384, 0, 0, 0, 0},
            '{-1, 0, 10000, 10000, 0, 0, 300, 0, 0, 0, 0, 0, 0},
            '{-1, 0, 0, -16384, 0, 0, 300, 0, 0, 0, 0, 0, 0}
        };

        in_ch.valid = 1'b0;
        in_ch.start_req = 1'b0;
        in_ch.in_w = '0;
        in_ch.in_x = '0;
        in_ch.in_y = '0;
        in_ch.in_z = '0;
        in_ch.weight = '0;
        avg_q = '{ONE, 0, 0, 0};
        total_wt = 0;
        have_set = 1'b0;
        thr_model = THR_RESET;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        foreach (rows[i]) begin
            if (rows[i].thr >= 0) begin
                drain_and_idle();
                write_threshold(rows[i].thr);
            end
            send_item(rows[i].start, rows[i].w, rows[i].x, rows[i].y, rows[i].z,
                      rows[i].wt, res);
            if (rows[i].typed && (res.w != rows[i].ew || res.x != rows[i].ex ||
                res.y != rows[i].ey || res.z != rows[i].ez || res.fault != rows[i].ef)) begin
                $display("%0t: row %0d expected %0d %0d %0d %0d f=%0b predicted %0d %0d %0d %0d f=%0b",
                         $realtime, i, rows[i].ew, rows[i].ex, rows[i].ey, rows[i].ez,
                         rows[i].ef, res.w, res.x, res.y, res.z, res.fault);
                errors++;
            end
            sender_gap();
        end

        thr_list = '{THR_RESET, 0, 16384, $urandom_range(0, 16384), THR_RESET};
        foreach (thr_list[p]) begin
            // The sender waits here until every expected transaction has come.
            drain_and_idle();
            write_threshold(thr_list[p]);
            rx_stall_pct = (p == 2) ? 0 : 20;
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                if (p == 1 && n == 40) hold_cycles = 1500;
                kind = $urandom_range(0, 99);
                start = (kind < 8);
                if (kind >= 8 && kind < 55) begin
                    w = near_comp(avg_q[0]);
                    x = near_comp(avg_q[1]);
                    y = near_comp(avg_q[2]);
                    z = near_comp(avg_q[3]);
                    if ($urandom_range(0, 1)) begin
                        w = -w; x = -x; y = -y; z = -z;
                    end
                end else begin
                    w = rand_comp();
                    x = rand_comp();
                    y = rand_comp();
                    z = rand_comp();
                end
                send_item(start, w, x, y, z, rand_weight(), res);
                sender_gap();
            end
        end

        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_avgs.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("quaternion_slerp_running_average_top_test: PASS");
        end else begin
            $display("quaternion_slerp_running_average_top_test: FAIL");
        end
        $finish;
    end

endmodule
